[hdl/crc32fp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package crc32fp_pkg;

   // Frame layout.
   localparam int unsigned HEADER_BYTES = 6;
   localparam int unsigned CRC_BYTES    = 4;

   // Widths of the channel payloads.
   localparam int unsigned COUNT_W    = 17;
   localparam int unsigned CSR_ADDR_W = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // CRC-32, reflected form.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Register reset values.
   localparam logic [7:0]  MAGIC_FIRST_RST      = 8'hA5;
   localparam logic [7:0]  MAGIC_SECOND_RST     = 8'h5A;
   localparam logic [7:0]  ACCEPTED_VERSION_RST = 8'h01;
   localparam logic [15:0] MAX_PAYLOAD_RST      = 16'd256;

   // Register indexes on the configuration channel.
   localparam logic [CSR_ADDR_W-1:0] CSR_MAGIC_FIRST      = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAGIC_SECOND     = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEPTED_VERSION = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_PAYLOAD      = 8'd3;

   // Kind of a result word.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_SHORT      = 3'd1,
      STATUS_BAD_MAGIC  = 3'd2,
      STATUS_BAD_VER    = 3'd3,
      STATUS_TOO_LARGE  = 3'd4,
      STATUS_LEN_MISMATCH = 3'd5,
      STATUS_BAD_CRC    = 3'd6
   } status_type;

   // One byte through the reflected CRC-32: eight shift/XOR steps.
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hdl/crc32fp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte stream into the parser.
interface crc32fp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Payload bytes and end-of-frame status out of the parser.
interface crc32fp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [7:0]  hdr_version;
   logic [7:0]  frame_type;
   logic [15:0] hdr_length;
   logic [31:0] received_crc;

   modport source (output valid, output result_kind, output payload_byte, output status,
                   output hdr_version, output frame_type, output hdr_length,
                   output received_crc, input ready);
   modport sink   (input valid, input result_kind, input payload_byte, input status,
                   input hdr_version, input frame_type, input hdr_length,
                   input received_crc, output ready);
endinterface

// Register write channel.
interface crc32fp_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/crc32_frame_parser_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Length-prefixed frame parser with CRC-32 check.
// req_chan carries one frame byte per word, with last_byte set on the final
// byte. rsp_chan returns a payload word for each byte in payload position
// (except the final byte of a frame) and one status word when the final byte
// arrives, carrying the header fields and the trailing four bytes.
// csr_chan writes the magic bytes, the accepted version and the payload limit;
// it is always ready and should be used only while no frame is in flight.
// Each byte is handled in the cycle it is accepted: the frame state and the
// CRC byte update sit between the request handshake and the result register,
// so a result is visible in the cycle after its byte is accepted, and one byte
// per cycle is sustained while the receiver keeps up. The limit on rate is the
// single result register: req_chan.ready drops only while that register holds
// a word that the receiver has not taken, so a stalled receiver stalls the byte
// stream, and a new byte is taken in the same cycle the waiting word drains.
// Reset (synchronous, active high) restores the register defaults, clears the
// frame state and empties the result register.
module crc32_frame_parser_top (
   input  wire                  clock,
   input  wire                  reset,
   crc32fp_req_if.sink          req_chan,
   crc32fp_rsp_if.source        rsp_chan,
   crc32fp_csr_if.sink          csr_chan
);
   import crc32fp_pkg::*;

   // Configuration registers.
   logic [7:0]  magic_first_ff, magic_second_ff, accepted_version_ff;
   logic [15:0] max_payload_ff;

   // Frame state.
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [31:0]        running_crc_ff, running_crc_in;
   logic               magic_bad_ff, magic_bad_in;
   logic [7:0]         version_byte_ff, version_byte_in;
   logic [7:0]         type_byte_ff, type_byte_in;
   logic [15:0]        declared_length_ff, declared_length_in;
   logic [31:0]        tail_bytes_ff, tail_bytes_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_payload_ff, rsp_payload_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_version_ff, rsp_version_in;
   logic [7:0]  rsp_type_ff, rsp_type_in;
   logic [15:0] rsp_length_ff, rsp_length_in;
   logic [31:0] rsp_crc_ff, rsp_crc_in;
   logic        rsp_load;

   // Values after this byte, before the end-of-frame clear.
   logic               req_fire;
   logic [7:0]         data;
   logic [COUNT_W-1:0] idx;
   logic [COUNT_W-1:0] step_count;
   logic [31:0]        step_crc;
   logic               step_magic_bad;
   logic [7:0]         step_version;
   logic [7:0]         step_type;
   logic [15:0]        step_length;
   logic [31:0]        step_tail;
   logic [COUNT_W-1:0] payload_end;
   logic [COUNT_W-1:0] frame_len;
   logic               payload_hit;
   status_type         frame_status;

   // The result register frees up when it is empty or being drained.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      data = req_chan.data_byte;
      idx  = byte_count_ff;

      step_magic_bad = magic_bad_ff
         || ((idx == COUNT_W'(0)) && (data != magic_first_ff))
         || ((idx == COUNT_W'(1)) && (data != magic_second_ff));
      step_version = (idx == COUNT_W'(2)) ? data : version_byte_ff;
      step_type    = (idx == COUNT_W'(3)) ? data : type_byte_ff;
      step_length  = declared_length_ff;
      if (idx == COUNT_W'(4)) begin
         step_length = {data, declared_length_ff[7:0]};
      end
      if (idx == COUNT_W'(5)) begin
         step_length = {declared_length_ff[15:8], data};
      end

      // The CRC trails the stream by four bytes, fed from the top of the tail.
      step_crc  = (idx >= COUNT_W'(CRC_BYTES))
                  ? crc_feed(running_crc_ff, tail_bytes_ff[31:24]) : running_crc_ff;
      step_tail = {tail_bytes_ff[23:0], data};
      step_count = (byte_count_ff != COUNT_MAX) ? byte_count_ff + COUNT_W'(1) : byte_count_ff;

      // Payload positions use the length as it stood before this byte; the
      // length bytes themselves lie ahead of the payload anyway.
      payload_end = COUNT_W'(HEADER_BYTES) + {1'b0, declared_length_ff};
      payload_hit = (idx >= COUNT_W'(HEADER_BYTES)) && (idx < payload_end);

      frame_len = COUNT_W'(HEADER_BYTES + CRC_BYTES) + {1'b0, step_length};
      if (step_count < COUNT_W'(HEADER_BYTES + CRC_BYTES)) begin
         frame_status = STATUS_SHORT;
      end else if (step_magic_bad) begin
         frame_status = STATUS_BAD_MAGIC;
      end else if (step_version != accepted_version_ff) begin
         frame_status = STATUS_BAD_VER;
      end else if (step_length > max_payload_ff) begin
         frame_status = STATUS_TOO_LARGE;
      end else if (step_count != frame_len) begin
         frame_status = STATUS_LEN_MISMATCH;
      end else if (step_tail != ~step_crc) begin
         frame_status = STATUS_BAD_CRC;
      end else begin
         frame_status = STATUS_OK;
      end

      // Frame state: hold, advance, or clear after the final byte.
      byte_count_in      = byte_count_ff;
      running_crc_in     = running_crc_ff;
      magic_bad_in       = magic_bad_ff;
      version_byte_in    = version_byte_ff;
      type_byte_in       = type_byte_ff;
      declared_length_in = declared_length_ff;
      tail_bytes_in      = tail_bytes_ff;
      if (req_fire) begin
         if (req_chan.last_byte) begin
            byte_count_in      = '0;
            running_crc_in     = CRC_INIT;
            magic_bad_in       = 1'b0;
            version_byte_in    = '0;
            type_byte_in       = '0;
            declared_length_in = '0;
            tail_bytes_in      = '0;
         end else begin
            byte_count_in      = step_count;
            running_crc_in     = step_crc;
            magic_bad_in       = step_magic_bad;
            version_byte_in    = step_version;
            type_byte_in       = step_type;
            declared_length_in = step_length;
            tail_bytes_in      = step_tail;
         end
      end

      // Result word for this byte, if any.
      rsp_load       = req_fire && (req_chan.last_byte || payload_hit);
      rsp_kind_in    = req_chan.last_byte ? KIND_STATUS : KIND_PAYLOAD;
      rsp_payload_in = req_chan.last_byte ? 8'd0 : data;
      rsp_status_in  = req_chan.last_byte ? frame_status : STATUS_OK;
      rsp_version_in = req_chan.last_byte ? step_version : 8'd0;
      rsp_type_in    = req_chan.last_byte ? step_type : 8'd0;
      rsp_length_in  = req_chan.last_byte ? step_length : 16'd0;
      rsp_crc_in     = req_chan.last_byte ? step_tail : 32'd0;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff      <= MAGIC_FIRST_RST;
         magic_second_ff     <= MAGIC_SECOND_RST;
         accepted_version_ff <= ACCEPTED_VERSION_RST;
         max_payload_ff      <= MAX_PAYLOAD_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_MAGIC_FIRST:      magic_first_ff      <= csr_chan.data[7:0];
            CSR_MAGIC_SECOND:     magic_second_ff     <= csr_chan.data[7:0];
            CSR_ACCEPTED_VERSION: accepted_version_ff <= csr_chan.data[7:0];
            CSR_MAX_PAYLOAD:      max_payload_ff      <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff      <= '0;
         running_crc_ff     <= CRC_INIT;
         magic_bad_ff       <= 1'b0;
         version_byte_ff    <= '0;
         type_byte_ff       <= '0;
         declared_length_ff <= '0;
         tail_bytes_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         byte_count_ff      <= byte_count_in;
         running_crc_ff     <= running_crc_in;
         magic_bad_ff       <= magic_bad_in;
         version_byte_ff    <= version_byte_in;
         type_byte_ff       <= type_byte_in;
         declared_length_ff <= declared_length_in;
         tail_bytes_ff      <= tail_bytes_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // Result payload needs no reset; it is qualified by rsp_valid_ff.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_version_ff <= rsp_version_in;
         rsp_type_ff    <= rsp_type_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_crc_ff     <= rsp_crc_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_kind_ff;
   assign rsp_chan.payload_byte = rsp_payload_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.hdr_version  = rsp_version_ff;
   assign rsp_chan.frame_type   = rsp_type_ff;
   assign rsp_chan.hdr_length   = rsp_length_ff;
   assign rsp_chan.received_crc = rsp_crc_ff;

`ifndef SYNTHESIS
   // A final byte always leaves a status word in the result register.
   a_last_gives_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.last_byte |=> rsp_valid_ff && (rsp_kind_ff == KIND_STATUS))
      else $error("final byte did not produce a status word");

   // A final byte clears the frame state for the next frame.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.last_byte |=> (byte_count_ff == '0) && !magic_bad_ff
         && (tail_bytes_ff == '0))
      else $error("frame state not cleared after final byte");

   // At the start of a frame the CRC sits at its initial value.
   a_crc_init: assert property (@(posedge clock) disable iff (reset)
      (byte_count_ff == '0) |-> (running_crc_ff == CRC_INIT))
      else $error("CRC not at initial value at frame start");

   // Bytes that are not final advance the count until it saturates.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_chan.last_byte && (byte_count_ff != COUNT_MAX)
      |=> byte_count_ff == $past(byte_count_ff) + COUNT_W'(1))
      else $error("byte count did not advance");

   // A stalled result word is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_fire)
      else $error("byte accepted while result register is full");
`endif

endmodule

`default_nettype wire
